FILE: src/pfsr_pkg.sv
// Package for the fixed-step polyline resampler.
// Item structs, fixed-point constants and default parameter values.
// Used by polyline_fixed_step_resampler; depends on nothing.
package pfsr_pkg;

   // Fixed-point formats
   localparam int FRACTION_BITS = 16;
   localparam int MAX_SAMPLES_DEFAULT = 62;
   localparam logic [31:0] STEP_RESET = 32'(1) << FRACTION_BITS;
   localparam int POS_FRAC = 30;
   localparam logic [33:0] POS_ONE = 34'(1) << POS_FRAC;
   localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

   // Input vertex item
   typedef struct packed {
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic [31:0]        in_radius;
      logic               last_vertex;
   } req_item_type;

   // Resampled point item
   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [31:0]        out_radius;
      logic               line_end;
      logic               run_last;
      logic               truncated;
   } rsp_item_type;

endpackage

FILE: src/polyline_fixed_step_resampler.sv
// Fixed-step polyline resampler, single module with one shared 32x32 multiplier.
// Depends on pfsr_pkg (item structs, constants).

// Vertices arrive one item at a time; each line is re-emitted as points spaced
// step_length apart along the line, radius interpolated linearly. Each vertex
// after the first of a line runs three squaring passes through the shared
// multiplier, a bit-serial square root, a length saturation check, a
// short-segment decision, a bit-serial division (skipped when the step
// saturates) and a cut-check multiply; each emitted sample then takes the
// interpolation multiplies for x, y, z and radius plus an output load, and the
// carried-distance multiply follows the last sample. A short segment only adds
// its length to the carried distance; the last vertex of a line is also
// emitted as the line end, and a final bookkeeping step follows. Output stalls
// hold the sequencer, and the input is not ready until its last point is
// loaded into the output register. The first vertex of a line is emitted as is.
// csr_write_data sets step_length (unsigned Q16.16).
module polyline_fixed_step_resampler
   import pfsr_pkg::*;
#(
   parameter int MAX_SAMPLES_PER_SEGMENT = MAX_SAMPLES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [31:0]  csr_write_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int CNT_W = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES_PER_SEGMENT);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES_PER_SEGMENT - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_SQ, S_ROOT, S_CHK, S_DIV, S_CUT, S_CUTW,
      S_LERP, S_EMIT, S_CARRY, S_CARRYW, S_LAST, S_FIN
   } state_type;

   state_type    state_ff;
   logic [31:0]  step_ff;
   req_item_type cur_ff;
   logic [31:0]  prev_x_ff, prev_y_ff, prev_z_ff, prev_r_ff;
   logic [31:0]  carried_ff;
   logic         inside_ff;
   logic [2:0]   fld_ff;
   logic [4:0]   iter_ff;
   logic [63:0]  sum_ff;
   logic         ovf_ff;
   logic [33:0]  rem_ff;
   logic [31:0]  root_ff;
   logic [31:0]  len_ff;
   logic [31:0]  ps_ff;
   logic [30:0]  pos_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic         cut_ff;
   logic [63:0]  prod_ff;
   logic         neg_ff;
   logic [32:0]  base_ff;
   logic [31:0]  lerp_ff [4];
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   // Field select and difference for squares and interpolation
   logic [1:0]         fsel;
   logic signed [32:0] a_sel, b_sel, d_sel;
   logic [32:0]        d_abs;
   logic [31:0]        mul_a, mul_b;

   always_comb begin
      fsel = fld_ff[1:0];
      unique case (fsel)
         2'd0: begin
            a_sel = {prev_x_ff[31], prev_x_ff};
            b_sel = {cur_ff.in_x[31], cur_ff.in_x};
         end
         2'd1: begin
            a_sel = {prev_y_ff[31], prev_y_ff};
            b_sel = {cur_ff.in_y[31], cur_ff.in_y};
         end
         2'd2: begin
            a_sel = {prev_z_ff[31], prev_z_ff};
            b_sel = {cur_ff.in_z[31], cur_ff.in_z};
         end
         default: begin
            a_sel = {1'b0, prev_r_ff};
            b_sel = {1'b0, cur_ff.in_radius};
         end
      endcase
      d_sel = b_sel - a_sel;
      d_abs = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
   end

   // Shared multiplier operands
   always_comb begin
      unique case (state_ff)
         S_SQ:    begin mul_a = d_abs[31:0];  mul_b = d_abs[31:0]; end
         S_LERP:  begin mul_a = d_abs[31:0];  mul_b = {1'b0, pos_ff}; end
         S_CUT:   begin mul_a = ps_ff;        mul_b = 32'(MAX_SAMPLES_PER_SEGMENT); end
         S_CARRY: begin mul_a = 32'(POS_ONE - {3'b0, pos_ff}); mul_b = len_ff; end
         default: begin mul_a = '0;           mul_b = '0; end
      endcase
   end

   // Square root step
   logic [35:0] rt_rem, rt_trial;
   assign rt_rem   = {rem_ff, sum_ff[63:62]};
   assign rt_trial = {2'b0, root_ff, 2'b01};

   // Division step
   logic        dv_bit;
   logic [32:0] dv_rem;
   assign dv_bit = (iter_ff == 5'd31) ? step_ff[1] : ((iter_ff == 5'd30) ? step_ff[0] : 1'b0);
   assign dv_rem = {rem_ff[31:0], dv_bit};

   // Short-segment test and saturation test
   logic signed [33:0] room;
   logic               is_short, ps_sat;
   assign room     = $signed({2'b0, step_ff}) - $signed({2'b0, carried_ff});
   assign is_short = $signed({2'b0, len_ff}) < room;
   assign ps_sat   = (len_ff == '0) || ({2'b0, step_ff[31:2]} >= len_ff);

   // Sample position bookkeeping
   logic [33:0] nx;
   logic        seg_last;
   assign nx       = {3'b0, pos_ff} + {2'b0, ps_ff};
   assign seg_last = (nx >= POS_ONE) || (cnt_ff >= CNT_LAST);

   // Interpolation result of the field issued in the previous cycle
   logic [31:0] q_lerp;
   logic [33:0] r_lerp;
   assign q_lerp = prod_ff[61:30];
   assign r_lerp = neg_ff ? ({base_ff[32], base_ff} - {2'b0, q_lerp})
                          : ({base_ff[32], base_ff} + {2'b0, q_lerp});

   logic out_free;
   logic rsp_load;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = out_free && (state_ff == S_FIRST || state_ff == S_EMIT
                                   || state_ff == S_LAST);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Multiplier output register
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // Sequencer, datapath registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         prev_r_ff    <= '0;
         carried_ff   <= '0;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         fld_ff       <= '0;
         iter_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            step_ff <= csr_write_data;
         end
         // output register: load a new point or drain the old one
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cur_ff   <= req_item;
                  cut_ff   <= 1'b0;
                  fld_ff   <= '0;
                  sum_ff   <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= inside_ff ? S_SQ : S_FIRST;
               end
            end
            S_FIRST: begin
               if (out_free) begin
                  rsp_ff <= '{out_x: cur_ff.in_x, out_y: cur_ff.in_y, out_z: cur_ff.in_z,
                              out_radius: cur_ff.in_radius, line_end: 1'b0,
                              run_last: !cur_ff.last_vertex, truncated: 1'b0};
                  state_ff <= cur_ff.last_vertex ? S_LAST : S_FIN;
               end
            end
            S_SQ: begin
               // issue one square per cycle, accumulate the one before
               if (fld_ff != '0) begin
                  {ovf_ff, sum_ff} <= {1'b0, sum_ff} + {1'b0, prod_ff} | {ovf_ff, 64'b0};
               end
               if (fld_ff == 3'd3) begin
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  iter_ff  <= 5'd31;
                  state_ff <= S_ROOT;
               end else begin
                  fld_ff <= fld_ff + 3'd1;
               end
            end
            S_ROOT: begin
               if (rt_rem >= rt_trial) begin
                  rem_ff  <= 34'(rt_rem - rt_trial);
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= rt_rem[33:0];
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               sum_ff  <= {sum_ff[61:0], 2'b00};
               iter_ff <= iter_ff - 5'd1;
               if (iter_ff == '0) begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               // a sum of squares past 64 bits saturates the length
               len_ff   <= ovf_ff ? MASK32 : root_ff;
               ovf_ff   <= 1'b0;
               iter_ff  <= 5'd31;
               fld_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // on entry decide short / saturated, else divide
               if (iter_ff == 5'd31 && fld_ff != 3'd7) begin
                  fld_ff <= 3'd7;
                  if (is_short) begin
                     carried_ff <= carried_ff + len_ff;
                     state_ff   <= cur_ff.last_vertex ? S_LAST : S_FIN;
                  end else if (ps_sat) begin
                     ps_ff    <= MASK32;
                     state_ff <= S_CUT;
                  end else begin
                     rem_ff <= {4'b0, step_ff[31:2]};
                  end
               end else begin
                  if (dv_rem >= {1'b0, len_ff}) begin
                     rem_ff <= {1'b0, dv_rem - {1'b0, len_ff}};
                     ps_ff  <= {ps_ff[30:0], 1'b1};
                  end else begin
                     rem_ff <= {1'b0, dv_rem};
                     ps_ff  <= {ps_ff[30:0], 1'b0};
                  end
                  iter_ff <= iter_ff - 5'd1;
                  if (iter_ff == '0) begin
                     state_ff <= S_CUT;
                  end
               end
            end
            S_CUT: begin
               state_ff <= S_CUTW;
            end
            S_CUTW: begin
               cut_ff   <= (prod_ff < 64'(POS_ONE));
               pos_ff   <= '0;
               cnt_ff   <= '0;
               fld_ff   <= '0;
               state_ff <= S_LERP;
            end
            S_LERP: begin
               if (fld_ff != '0) begin
                  lerp_ff[2'(fld_ff - 3'd1)] <= r_lerp[31:0];
               end
               neg_ff  <= d_sel[32];
               base_ff <= a_sel;
               if (fld_ff == 3'd4) begin
                  state_ff <= S_EMIT;
               end else begin
                  fld_ff <= fld_ff + 3'd1;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff <= '{out_x: lerp_ff[0], out_y: lerp_ff[1], out_z: lerp_ff[2],
                              out_radius: lerp_ff[3], line_end: 1'b0,
                              run_last: seg_last && !cur_ff.last_vertex,
                              truncated: cut_ff};
                  fld_ff <= '0;
                  if (seg_last) begin
                     if (nx == POS_ONE) begin
                        pos_ff <= POS_ONE[30:0];
                     end
                     state_ff <= S_CARRY;
                  end else begin
                     pos_ff   <= nx[30:0];
                     cnt_ff   <= cnt_ff + CNT_W'(1);
                     state_ff <= S_LERP;
                  end
               end
            end
            S_CARRY: begin
               state_ff <= S_CARRYW;
            end
            S_CARRYW: begin
               carried_ff <= prod_ff[61:30];
               state_ff   <= cur_ff.last_vertex ? S_LAST : S_FIN;
            end
            S_LAST: begin
               if (out_free) begin
                  rsp_ff <= '{out_x: cur_ff.in_x, out_y: cur_ff.in_y, out_z: cur_ff.in_z,
                              out_radius: cur_ff.in_radius, line_end: 1'b1,
                              run_last: 1'b1, truncated: cut_ff};
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               prev_x_ff <= cur_ff.in_x;
               prev_y_ff <= cur_ff.in_y;
               prev_z_ff <= cur_ff.in_z;
               prev_r_ff <= cur_ff.in_radius;
               inside_ff <= !cur_ff.last_vertex;
               if (cur_ff.last_vertex) begin
                  carried_ff <= '0;
               end
               iter_ff  <= 5'd31;
               fld_ff   <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("sample count beyond maximum");

   a_last_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LAST && out_free |=> rsp_valid && rsp_item.line_end && rsp_item.run_last)
      else $error("line end not emitted");

   a_idle_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |=> req_ready)
      else $error("sequencer did not return to idle");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for polyline_fixed_step_resampler.
// A scoreboard class predicts the resampled points of every accepted vertex;
// depends on pfsr_pkg and the block's RTL.
module testbench;
   import pfsr_pkg::*;

   localparam longint unsigned POS_UNIT = 64'd1 << 30;
   localparam int DRAIN_CYCLES = 800;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 3000;

   // Predicts resampled points and checks them in order
   class resample_scoreboard;
      logic [31:0] step_len;
      logic [31:0] last_x, last_y, last_z, last_rad;
      logic [31:0] carry_dist;
      bit in_line;
      rsp_item_type points_due[$];
      int errors, vertices, points, cut_points;

      function new();
         step_len = STEP_RESET;
         last_x = 0; last_y = 0; last_z = 0; last_rad = 0;
         carry_dist = 0;
         in_line = 0;
         errors = 0; vertices = 0; points = 0; cut_points = 0;
      endfunction

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function logic [31:0] interp(longint a, longint b, longint unsigned pos);
         longint d;
         longint unsigned mag, q;
         d = b - a;
         mag = (d < 0) ? longint'(-d) : longint'(d);
         q = (mag * pos) >> 30;
         return (d < 0) ? 32'(a - longint'(q)) : 32'(a + longint'(q));
      endfunction

      function longint unsigned diff_sq(logic [31:0] a, logic [31:0] b);
         longint d;
         longint unsigned mag;
         d = longint'($signed(b)) - longint'($signed(a));
         mag = (d < 0) ? longint'(-d) : longint'(d);
         return mag * mag;
      endfunction

      function void set_step(logic [31:0] value);
         step_len = value;
      endfunction

      // Works out every point caused by one accepted vertex
      function void note_vertex(req_item_type v);
         rsp_item_type pts[$];
         rsp_item_type pt;
         longint unsigned sa, sb, sc, s1, s2, pstep, pos, nxt;
         logic [31:0] seg_len;
         bit ovf, cut;
         int cnt;
         cut = 0;
         vertices++;
         pt = '0;
         if (!in_line) begin
            pt.out_x = v.in_x; pt.out_y = v.in_y; pt.out_z = v.in_z;
            pt.out_radius = v.in_radius;
            pts.push_back(pt);
         end else begin
            sa = diff_sq(last_x, v.in_x);
            sb = diff_sq(last_y, v.in_y);
            sc = diff_sq(last_z, v.in_z);
            s1 = sa + sb;
            ovf = s1 < sa;
            s2 = s1 + sc;
            if (s2 < s1) ovf = 1;
            seg_len = ovf ? MASK32 : 32'(isqrt(s2));
            if (longint'(seg_len) < longint'(step_len) - longint'(carry_dist)) begin
               // short segment: only the carried distance grows
               carry_dist = carry_dist + seg_len;
            end else begin
               if (seg_len == 0) pstep = MASK32;
               else begin
                  pstep = (longint'(step_len) << 30) / seg_len;
                  if (pstep > MASK32) pstep = MASK32;
               end
               pos = 0;
               cnt = 0;
               while (pos < POS_UNIT) begin
                  pt = '0;
                  pt.out_x = interp($signed(last_x), $signed(v.in_x), pos);
                  pt.out_y = interp($signed(last_y), $signed(v.in_y), pos);
                  pt.out_z = interp($signed(last_z), $signed(v.in_z), pos);
                  pt.out_radius = interp(longint'(last_rad), longint'(v.in_radius), pos);
                  pts.push_back(pt);
                  cnt++;
                  nxt = pos + pstep;
                  if (nxt > POS_UNIT) break;
                  if (nxt < POS_UNIT && cnt >= MAX_SAMPLES_DEFAULT) begin
                     cut = 1;
                     break;
                  end
                  pos = nxt;
               end
               carry_dist = 32'(((POS_UNIT - pos) * longint'(seg_len)) >> 30);
            end
         end
         // end of line: last vertex goes out as is
         if (v.last_vertex) begin
            pt = '0;
            pt.out_x = v.in_x; pt.out_y = v.in_y; pt.out_z = v.in_z;
            pt.out_radius = v.in_radius;
            pt.line_end = 1;
            pts.push_back(pt);
            in_line = 0;
            carry_dist = 0;
         end else begin
            in_line = 1;
         end
         last_x = v.in_x; last_y = v.in_y; last_z = v.in_z; last_rad = v.in_radius;
         foreach (pts[k]) begin
            pts[k].truncated = cut;
            pts[k].run_last = (k == pts.size() - 1);
            points_due.push_back(pts[k]);
         end
      endfunction

      // Compares one accepted point against the oldest expectation
      function void check_point(rsp_item_type got);
         rsp_item_type want;
         points++;
         if (got.truncated) cut_points++;
         if (points_due.size() == 0) begin
            $error("unexpected point x=%h y=%h z=%h", got.out_x, got.out_y, got.out_z);
            errors++;
            return;
         end
         want = points_due.pop_front();
         if (got.out_x !== want.out_x) begin
            $error("out_x expected %h got %h", want.out_x, got.out_x); errors++;
         end
         if (got.out_y !== want.out_y) begin
            $error("out_y expected %h got %h", want.out_y, got.out_y); errors++;
         end
         if (got.out_z !== want.out_z) begin
            $error("out_z expected %h got %h", want.out_z, got.out_z); errors++;
         end
         if (got.out_radius !== want.out_radius) begin
            $error("out_radius expected %h got %h", want.out_radius, got.out_radius);
            errors++;
         end
         if (got.line_end !== want.line_end) begin
            $error("line_end expected %b got %b", want.line_end, got.line_end); errors++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last expected %b got %b", want.run_last, got.run_last); errors++;
         end
         if (got.truncated !== want.truncated) begin
            $error("truncated expected %b got %b", want.truncated, got.truncated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [31:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_ready;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_item_type rsp_item;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_req = 0;
   bit hold_taken = 0;
   int hold_off = 0;
   int cycles = 0;
   resample_scoreboard board = new();

   polyline_fixed_step_resampler dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_req && !hold_taken) begin
         rsp_ready <= 0;
         hold_taken <= 1;
         hold_off <= HOLD_CYCLES;
      end else if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_point(rsp_item);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offers one vertex item and waits for it to be taken
   task automatic send_vertex(req_item_type v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_item <= v;
      do @(posedge clock); while (!req_ready);
      board.note_vertex(v);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (board.points_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(logic [31:0] value);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      board.set_step(value);
   endtask

   function automatic req_item_type vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [31:0] r, logic lastv);
      req_item_type v;
      v.in_x = x; v.in_y = y; v.in_z = z; v.in_radius = r; v.last_vertex = lastv;
      return v;
   endfunction

   // One random polyline: mostly a walk around a random start, some wild jumps
   task automatic send_line(int nverts, int span);
      logic [31:0] cx, cy, cz;
      int pick;
      cx = $urandom; cy = $urandom; cz = $urandom;
      for (int i = 0; i < nverts; i++) begin
         pick = $urandom_range(99);
         if (i > 0 && pick < 6) begin
            cx = $urandom; cy = $urandom; cz = $urandom;
         end else if (i > 0 && pick >= 10) begin
            cx = cx + $urandom_range(2 * span) - span;
            cy = cy + $urandom_range(2 * span) - span;
            cz = cz + $urandom_range(2 * span) - span;
         end
         send_vertex(vertex(cx, cy, cz, $urandom, i == nverts - 1));
      end
   endtask

   task automatic random_lines(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
         send_line(n, 1 << $urandom_range(12, 22));
         sent += n;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, single vertex, short and zero segments, saturation
      write_step(32'h0001_0000);
      send_vertex(vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1));
      send_vertex(vertex(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 0));
      send_vertex(vertex(32'h8000, 32'h0, 32'h0, 32'h1000, 0));
      send_vertex(vertex(32'h8000, 32'h0, 32'h0, 32'h1000, 0));
      send_vertex(vertex(32'h3_0000, 32'h4_0000, 32'h0, 32'h0, 0));
      send_vertex(vertex(32'h3_0000, 32'h4_0000, 32'h0, 32'h0, 0));
      send_vertex(vertex(32'h4_0000, 32'h4_0000, 32'h0, 32'h7FFF_FFFF, 1));
      send_vertex(vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 0));
      send_vertex(vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1));
      send_vertex(vertex(32'hFFFF_0000, 32'h0, 32'h0, 32'h5, 0));
      send_vertex(vertex(32'hFFFF_0000, 32'h0, 32'h64_0000, 32'h0, 1));
      wait_idle();

      // Phase one: sender idles less than receiver stalls
      write_step(32'h0004_0000);
      send_idle_pct = 28; recv_stall_pct = 47;
      random_lines(70);
      wait_idle();

      // Phase two: largest step, roles swapped
      write_step(32'hFFFF_FFFF);
      send_idle_pct = 47; recv_stall_pct = 28;
      random_lines(60);
      wait_idle();

      // Phase three: smallest step, no idling, one long receiver hold-off, then a larger step
      write_step(32'h0000_0001);
      send_idle_pct = 0; recv_stall_pct = 0;
      hold_req = 1;
      random_lines(25);
      wait_idle();
      write_step(32'h0002_8000);
      random_lines(45);
      wait_idle();

      $display("Run covered %0d vertices and %0d resampled points, %0d of them truncated.",
               board.vertices, board.points, board.cut_points);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
